>>> rtl/core/ilid_pkg.sv
package ilid_pkg;

  localparam int WordW = 32;
  localparam int PosW  = 7;

  typedef logic signed [WordW-1:0] word_t;

  localparam logic [PosW-1:0] CapReset = 7'd64;

  typedef enum logic [1:0] {
    K_APPEND = 2'd0,
    K_INSERT = 2'd1,
    K_DELETE = 2'd2,
    K_READ   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WAIT   = 3'b010,
    S_COMMIT = 3'b100
  } state_e;

  typedef struct packed {
    logic            ins;
    logic            del;
    logic [PosW-1:0] pos;
    word_t           val;
  } cmd_t;

endpackage

>>> rtl/core/indexed_list_insert_delete.sv
// Ordered list of signed 32-bit words held in a row of DEPTH cells, one word
// per cell. Append and insert shift the cells at and above the position up by
// one, delete shifts them down; the capacity register (reset 64, limited to
// DEPTH) bounds the count. An append or insert goes from acceptance through
// S_COMMIT back to S_IDLE. A read or delete first waits in S_WAIT for the
// registered OR tree that picks the cell at the position, then commits. A
// finished result waits in the output register while the next transaction is
// accepted, but it must be taken before that transaction can complete.
// Configuration writes are always accepted and must only be issued while no
// transaction is in flight.
module indexed_list_insert_delete import ilid_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             kind_i,
  input  logic [PosW-1:0]        position_i,
  input  logic signed [WordW-1:0] value_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [WordW-1:0] data_out_o,
  output logic [1:0]             status_o,
  output logic [PosW-1:0]        count_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [PosW-1:0]        cfg_capacity_i
);

  localparam int Lvl   = $clog2(DEPTH);
  localparam int WaitW = $clog2(Lvl + 1);

  state_e          state_q, state_d;
  kind_e           kind_q;
  logic [PosW-1:0] pos_q;
  word_t           val_q;
  logic [PosW-1:0] count_q, count_d;
  logic [PosW-1:0] cap_q;
  logic [WaitW-1:0] wait_q, wait_d;
  logic            out_valid_q;
  word_t           data_q;
  status_e         status_q;

  logic            in_fire;
  logic            commit_go;
  logic [PosW-1:0] limit;
  logic            full;
  logic            do_ins, do_del, use_tree;
  logic [PosW-1:0] ins_pos;
  status_e         res_status;
  cmd_t            cmd;
  word_t           root;
  word_t           entry_w [DEPTH];
  word_t           tap_w [DEPTH];

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign commit_go   = (state_q == S_COMMIT) && (!out_valid_q || out_ready_i);

  assign limit = ({{(32-PosW){1'b0}}, cap_q} > 32'(DEPTH)) ? PosW'(DEPTH) : cap_q;
  assign full  = (count_q >= limit);

  always_comb begin
    do_ins     = 1'b0;
    do_del     = 1'b0;
    use_tree   = 1'b0;
    ins_pos    = pos_q;
    res_status = ST_DONE;
    case (kind_q)
      K_APPEND: begin
        ins_pos = count_q;
        if (full) begin
          res_status = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      K_INSERT: begin
        if (full) begin
          res_status = ST_FULL;
        end else if (pos_q > count_q) begin
          res_status = ST_RANGE;
        end else begin
          do_ins = 1'b1;
        end
      end
      K_DELETE: begin
        if (pos_q >= count_q) begin
          res_status = ST_RANGE;
        end else begin
          do_del   = 1'b1;
          use_tree = 1'b1;
        end
      end
      K_READ: begin
        if (pos_q >= count_q) begin
          res_status = ST_RANGE;
        end else begin
          use_tree = 1'b1;
        end
      end
      default: begin
        res_status = ST_RANGE;
      end
    endcase
  end

  always_comb begin
    cmd.ins = commit_go && do_ins;
    cmd.del = commit_go && do_del;
    cmd.pos = ins_pos;
    cmd.val = val_q;
    count_d = count_q;
    if (cmd.ins) begin
      count_d = count_q + PosW'(1);
    end else if (cmd.del) begin
      count_d = count_q - PosW'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t left_w;
    word_t right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = entry_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = entry_w[i];
    end else begin : g_right
      assign right_w = entry_w[i+1];
    end
    ilid_cell #(
      .Index(i)
    ) u_cell (
      .clk_i  (clk_i),
      .cmd_i  (cmd),
      .left_i (left_w),
      .right_i(right_w),
      .entry_o(entry_w[i]),
      .tap_o  (tap_w[i])
    );
  end

  ilid_or_tree #(
    .N(DEPTH)
  ) u_tree (
    .clk_i (clk_i),
    .leaf_i(tap_w),
    .root_o(root)
  );

  always_comb begin
    state_d = state_q;
    wait_d  = wait_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if ((kind_e'(kind_i) == K_DELETE) || (kind_e'(kind_i) == K_READ)) begin
            state_d = S_WAIT;
            wait_d  = WaitW'(Lvl - 1);
          end else begin
            state_d = S_COMMIT;
          end
        end
      end
      S_WAIT: begin
        if (wait_q == '0) begin
          state_d = S_COMMIT;
        end else begin
          wait_d = wait_q - WaitW'(1);
        end
      end
      S_COMMIT: begin
        if (commit_go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wait_q      <= '0;
      count_q     <= '0;
      cap_q       <= CapReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
      count_q <= count_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_capacity_i;
      end
      if (commit_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q <= kind_e'(kind_i);
      pos_q  <= position_i;
      val_q  <= value_i;
    end
    if (commit_go) begin
      data_q   <= use_tree ? root : '0;
      status_q <= res_status;
    end
  end

  logic [PosW-1:0] count_out_q;

  always_ff @(posedge clk_i) begin
    if (commit_go) begin
      count_out_q <= count_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = data_q;
  assign status_o    = status_q;
  assign count_o     = count_out_q;

  a_one_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.ins && cmd.del))
    else $error("Insert and delete shifts were issued together.");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      ((count_q == $past(count_q) + PosW'(1)) || (count_q == $past(count_q) - PosW'(1))))
    else $error("Entry count moved by more than one.");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {{(32-PosW){1'b0}}, count_q} <= 32'(DEPTH))
    else $error("Entry count exceeds the number of cells.");

  a_commit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_go |=> (out_valid_q && (state_q == S_IDLE)))
    else $error("A completed transaction did not reach the output register.");

  a_select_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && ((kind_i == K_DELETE) || (kind_i == K_READ))) |=> (state_q == S_WAIT))
    else $error("A read or delete skipped the selection wait.");

endmodule

>>> rtl/core/ilid_cell.sv
module ilid_cell import ilid_pkg::*; #(
  parameter int Index = 0
) (
  input  logic  clk_i,
  input  cmd_t  cmd_i,
  input  word_t left_i,
  input  word_t right_i,
  output word_t entry_o,
  output word_t tap_o
);

  localparam logic [31:0] IdxU = 32'(Index);

  word_t entry_q;
  word_t entry_d;
  logic  at_pos;
  logic  above;

  assign at_pos = ({{(32-PosW){1'b0}}, cmd_i.pos} == IdxU);
  assign above  = ({{(32-PosW){1'b0}}, cmd_i.pos} < IdxU);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (at_pos) begin
        entry_d = cmd_i.val;
      end else if (above) begin
        entry_d = left_i;
      end
    end else if (cmd_i.del && (at_pos || above)) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign tap_o   = at_pos ? entry_q : '0;

endmodule

>>> rtl/core/ilid_or_tree.sv
module ilid_or_tree import ilid_pkg::*; #(
  parameter int N = 64
) (
  input  logic  clk_i,
  input  word_t leaf_i [N],
  output word_t root_o
);

  localparam int Lvl = $clog2(N);
  localparam int P   = 1 << Lvl;

  word_t leaf_w [P];
  word_t node_q [1:P-1];

  for (genvar j = 0; j < P; j++) begin : g_leaf
    if (j < N) begin : g_used
      assign leaf_w[j] = leaf_i[j];
    end else begin : g_pad
      assign leaf_w[j] = '0;
    end
  end

  for (genvar k = 1; k < P; k++) begin : g_node
    if (2 * k < P) begin : g_inner
      always_ff @(posedge clk_i) begin
        node_q[k] <= node_q[2*k] | node_q[2*k+1];
      end
    end else begin : g_bottom
      always_ff @(posedge clk_i) begin
        node_q[k] <= leaf_w[2*k-P] | leaf_w[2*k+1-P];
      end
    end
  end

  assign root_o = node_q[1];

endmodule
